@@ hdl/bnc_pkg.sv @@
// ----------------------------------------------------------------------------
// bnc_pkg
// Shared types and constants for the binary 3x3 neighbourhood counter.
// ----------------------------------------------------------------------------
package bnc_pkg;

    localparam int DEF_MAX_COLS = 32;
    localparam int POS_W        = 5;
    localparam int SIZE_W       = 6;
    localparam int CNT_W        = 4;
    localparam int CFG_IDX_W    = 1;
    localparam int ROWS_LIMIT   = 32;

    localparam logic [SIZE_W-1:0] RESET_SIZE = 6'd6;

    localparam logic [CFG_IDX_W-1:0] REG_GRID_COLS = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GRID_ROWS = 1'd1;

    // which window the datapath evaluates
    typedef enum logic [1:0] {
        SEL_DIAG  = 2'd0,   // cell above-left of the new cell
        SEL_EDGE  = 2'd1,   // cell directly above, at the row end
        SEL_FLUSH = 2'd2    // final row sweep at frame end
    } sel_t;

    typedef struct packed {
        logic accept;
        logic push;
        sel_t sel;
        logic flush_inc;
        logic advance;
        logic last_of_run;
        logic frame_done;
    } cmd_t;

    typedef struct packed {
        logic has_diag;
        logic has_edge;
        logic frame_end;
        logic flush_last;
        logic out_free;
    } sts_t;

endpackage

@@ hdl/bnc_ctrl.sv @@
// ----------------------------------------------------------------------------
// bnc_ctrl
// Sequencer: takes one item, then issues one result push per cycle while the
// output register has room, and finally advances the grid position.
// ----------------------------------------------------------------------------
module bnc_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  bnc_pkg::sts_t sts,
    output bnc_pkg::cmd_t cmd
);
    import bnc_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_DIAG  = 4'b0010,
        ST_EDGE  = 4'b0100,
        ST_FLUSH = 4'b1000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next      = state_reg;
        cmd             = '0;
        cmd.sel         = SEL_DIAG;
        in_ready        = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    if (sts.has_diag)
                        state_next = ST_DIAG;
                    else if (sts.has_edge)
                        state_next = ST_EDGE;
                    else if (sts.frame_end)
                        state_next = ST_FLUSH;
                    else
                        cmd.advance = 1'b1;
                end
            end
            ST_DIAG:
            begin
                cmd.sel = SEL_DIAG;
                if (sts.out_free)
                begin
                    cmd.push        = 1'b1;
                    cmd.last_of_run = !sts.has_edge && !sts.frame_end;
                    if (sts.has_edge)
                        state_next = ST_EDGE;
                    else if (sts.frame_end)
                        state_next = ST_FLUSH;
                    else
                    begin
                        cmd.advance = 1'b1;
                        state_next  = ST_IDLE;
                    end
                end
            end
            ST_EDGE:
            begin
                cmd.sel = SEL_EDGE;
                if (sts.out_free)
                begin
                    cmd.push        = 1'b1;
                    cmd.last_of_run = !sts.frame_end;
                    if (sts.frame_end)
                        state_next = ST_FLUSH;
                    else
                    begin
                        cmd.advance = 1'b1;
                        state_next  = ST_IDLE;
                    end
                end
            end
            ST_FLUSH:
            begin
                cmd.sel = SEL_FLUSH;
                if (sts.out_free)
                begin
                    cmd.push      = 1'b1;
                    cmd.flush_inc = 1'b1;
                    if (sts.flush_last)
                    begin
                        cmd.last_of_run = 1'b1;
                        cmd.frame_done  = 1'b1;
                        cmd.advance     = 1'b1;
                        state_next      = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

@@ hdl/bnc_datapath.sv @@
// ----------------------------------------------------------------------------
// bnc_datapath
// Size registers, three row buffers, grid position, window adder and the
// output register.
// ----------------------------------------------------------------------------
module bnc_datapath #(
    parameter int MAX_COLS = bnc_pkg::DEF_MAX_COLS
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_valid,
    input  logic [bnc_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [bnc_pkg::SIZE_W-1:0]          cfg_data,
    input  logic                                cell_set,
    input  bnc_pkg::cmd_t                       cmd,
    output bnc_pkg::sts_t                       sts,
    input  logic                                out_ready,
    output logic                                out_valid,
    output logic [bnc_pkg::CNT_W-1:0]           out_count,
    output logic [bnc_pkg::POS_W-1:0]           out_row,
    output logic [bnc_pkg::POS_W-1:0]           out_col,
    output logic                                out_last,
    output logic                                out_done
);
    import bnc_pkg::*;

    // positions are 5 bits, so at most 32 columns are ever stored
    localparam int COLS_CAP = (MAX_COLS < 32) ? MAX_COLS : 32;
    localparam int ROWS_CAP = (ROWS_LIMIT < 32) ? ROWS_LIMIT : 32;
    localparam logic [SIZE_W-1:0] COLS_LIM = SIZE_W'(COLS_CAP);
    localparam logic [SIZE_W-1:0] ROWS_LIM = SIZE_W'(ROWS_CAP);

    logic [SIZE_W-1:0]   grid_cols_reg;
    logic [SIZE_W-1:0]   grid_rows_reg;
    logic [SIZE_W-1:0]   cols_eff;
    logic [SIZE_W-1:0]   rows_eff;

    logic [POS_W-1:0]    row_pos_reg, row_pos_next;
    logic [POS_W-1:0]    col_pos_reg, col_pos_next;
    logic [POS_W-1:0]    flush_col_reg;
    logic [COLS_CAP-1:0] older_reg, older_next;
    logic [COLS_CAP-1:0] prior_reg, prior_next;
    logic [COLS_CAP-1:0] current_reg, current_next;
    logic [COLS_CAP-1:0] cur_wr;
    logic [COLS_CAP-1:0] cur_src;

    logic                last_col;
    logic                last_row;

    logic [COLS_CAP-1:0] top_row, mid_row, bot_row;
    logic [POS_W-1:0]    tgt_col;
    logic [POS_W-1:0]    res_row;
    logic [SIZE_W-1:0]   tgt_ext;
    logic [8:0]          win_bits;
    logic [CNT_W-1:0]    win_count;

    logic                out_valid_reg;
    logic [CNT_W-1:0]    out_count_reg;
    logic [POS_W-1:0]    out_row_reg;
    logic [POS_W-1:0]    out_col_reg;
    logic                out_last_reg;
    logic                out_done_reg;

    // zero acts as one, oversize saturates
    always_comb
    begin
        cols_eff = (grid_cols_reg == '0) ? SIZE_W'(1) : grid_cols_reg;
        if (cols_eff > COLS_LIM)
            cols_eff = COLS_LIM;
        rows_eff = (grid_rows_reg == '0) ? SIZE_W'(1) : grid_rows_reg;
        if (rows_eff > ROWS_LIM)
            rows_eff = ROWS_LIM;
    end

    assign last_col = ({1'b0, col_pos_reg} + SIZE_W'(1)) >= cols_eff;
    assign last_row = ({1'b0, row_pos_reg} + SIZE_W'(1)) >= rows_eff;

    assign sts.has_diag   = (row_pos_reg != '0) && (col_pos_reg != '0);
    assign sts.has_edge   = (row_pos_reg != '0) && last_col;
    assign sts.frame_end  = last_col && last_row;
    assign sts.flush_last = ({1'b0, flush_col_reg} + SIZE_W'(1)) >= cols_eff;
    assign sts.out_free   = !out_valid_reg || out_ready;

    // new cell merged into the current row
    always_comb
    begin
        cur_wr = current_reg;
        for (int k = 0; k < COLS_CAP; k++)
        begin
            if (POS_W'(k) == col_pos_reg)
                cur_wr[k] = cell_set;
        end
    end

    assign cur_src = cmd.accept ? cur_wr : current_reg;

    always_comb
    begin
        older_next   = older_reg;
        prior_next   = prior_reg;
        current_next = cmd.accept ? cur_wr : current_reg;
        row_pos_next = row_pos_reg;
        col_pos_next = col_pos_reg;
        if (cmd.advance)
        begin
            if (last_col && last_row)
            begin
                older_next   = '0;
                prior_next   = '0;
                current_next = '0;
                row_pos_next = '0;
                col_pos_next = '0;
            end
            else if (last_col)
            begin
                older_next   = prior_reg;
                prior_next   = cur_src;
                current_next = '0;
                row_pos_next = row_pos_reg + POS_W'(1);
                col_pos_next = '0;
            end
            else
            begin
                col_pos_next = col_pos_reg + POS_W'(1);
            end
        end
    end

    // window rows and centre column for the selected result
    always_comb
    begin
        case (cmd.sel)
            SEL_FLUSH:
            begin
                top_row = (row_pos_reg != '0) ? prior_reg : '0;
                mid_row = current_reg;
                bot_row = '0;
                tgt_col = flush_col_reg;
                res_row = row_pos_reg;
            end
            SEL_EDGE:
            begin
                top_row = (row_pos_reg > POS_W'(1)) ? older_reg : '0;
                mid_row = prior_reg;
                bot_row = current_reg;
                tgt_col = col_pos_reg;
                res_row = row_pos_reg - POS_W'(1);
            end
            default:
            begin
                top_row = (row_pos_reg > POS_W'(1)) ? older_reg : '0;
                mid_row = prior_reg;
                bot_row = current_reg;
                tgt_col = col_pos_reg - POS_W'(1);
                res_row = row_pos_reg - POS_W'(1);
            end
        endcase
    end

    assign tgt_ext = {1'b0, tgt_col};

    // gather the 3x3 bits; columns at or past the grid width read as zero
    always_comb
    begin
        win_bits = '0;
        for (int k = 0; k < COLS_CAP; k++)
        begin
            if (SIZE_W'(k) < cols_eff)
            begin
                if (SIZE_W'(k) + SIZE_W'(1) == tgt_ext)
                begin
                    win_bits[0] = top_row[k];
                    win_bits[3] = mid_row[k];
                    win_bits[6] = bot_row[k];
                end
                if (SIZE_W'(k) == tgt_ext)
                begin
                    win_bits[1] = top_row[k];
                    win_bits[4] = mid_row[k];
                    win_bits[7] = bot_row[k];
                end
                if (SIZE_W'(k) == tgt_ext + SIZE_W'(1))
                begin
                    win_bits[2] = top_row[k];
                    win_bits[5] = mid_row[k];
                    win_bits[8] = bot_row[k];
                end
            end
        end
    end

    assign win_count = CNT_W'($countones(win_bits));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_cols_reg <= RESET_SIZE;
            grid_rows_reg <= RESET_SIZE;
            row_pos_reg   <= '0;
            col_pos_reg   <= '0;
            flush_col_reg <= '0;
            older_reg     <= '0;
            prior_reg     <= '0;
            current_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                case (cfg_index)
                    REG_GRID_COLS: grid_cols_reg <= cfg_data;
                    REG_GRID_ROWS: grid_rows_reg <= cfg_data;
                    default:       grid_cols_reg <= grid_cols_reg;
                endcase
            end
            if (cmd.accept)
                flush_col_reg <= '0;
            else if (cmd.flush_inc)
                flush_col_reg <= flush_col_reg + POS_W'(1);
            row_pos_reg <= row_pos_next;
            col_pos_reg <= col_pos_next;
            older_reg   <= older_next;
            prior_reg   <= prior_next;
            current_reg <= current_next;
            if (cmd.push)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.push)
        begin
            out_count_reg <= win_count;
            out_row_reg   <= res_row;
            out_col_reg   <= tgt_col;
            out_last_reg  <= cmd.last_of_run;
            out_done_reg  <= cmd.frame_done;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_count = out_count_reg;
    assign out_row   = out_row_reg;
    assign out_col   = out_col_reg;
    assign out_last  = out_last_reg;
    assign out_done  = out_done_reg;

endmodule

@@ hdl/binary_neighbourhood_count_3x3.sv @@
// ----------------------------------------------------------------------------
// binary_neighbourhood_count_3x3
// Streaming 3x3 box count over a binary raster grid, one cell per item.
// ----------------------------------------------------------------------------
// An item that produces no result is taken and advances the position at once;
// otherwise its results are pushed in turn after it is taken, and at the frame end
// the final row is swept one column per cycle while the output register has room.
// Results leave through the output register; the first is pushed in the state after acceptance.
// Reset: grid set to 6 x 6, row buffers cleared, position at row 0, col 0.
// ----------------------------------------------------------------------------
module binary_neighbourhood_count_3x3 #(
    parameter int MAX_COLS = bnc_pkg::DEF_MAX_COLS
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [7:0]                    s_axis_tdata,   // [0] cell_set
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [15:0]                   m_axis_tdata,   // [3:0] neighbour_count,
                                                          // [8:4] out_row, [13:9] out_col
    output logic                          m_axis_tlast,   // last_of_run
    output logic                          m_axis_tuser,   // frame_done
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [bnc_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [bnc_pkg::SIZE_W-1:0]    cfg_data
);
    import bnc_pkg::*;

    cmd_t             cmd;
    sts_t             sts;
    logic [CNT_W-1:0] count;
    logic [POS_W-1:0] row;
    logic [POS_W-1:0] col;

    assign cfg_ready = 1'b1;

    bnc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    bnc_datapath #(
        .MAX_COLS (MAX_COLS)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cell_set  (s_axis_tdata[0]),
        .cmd       (cmd),
        .sts       (sts),
        .out_ready (m_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_count (count),
        .out_row   (row),
        .out_col   (col),
        .out_last  (m_axis_tlast),
        .out_done  (m_axis_tuser)
    );

    assign m_axis_tdata = {2'b00, col, row, count};

    a_done_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tuser) |-> m_axis_tlast)
        else $error("frame done without last of run");

    a_push_has_room: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.push |-> sts.out_free)
        else $error("result pushed over an untaken result");

    a_no_push_while_taking: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tready |-> !cmd.push)
        else $error("result pushed while taking a new item");

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tdata[3:0] <= 4'd9))
        else $error("neighbour count above nine");

endmodule

@@ dv/box_count_check_pkg.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// box_count_check_pkg
// Tracks the grid position and row buffers of the 3x3 neighbourhood counter,
// predicts the counts each accepted cell releases and checks results in order.
// ----------------------------------------------------------------------------
package box_count_check_pkg;

    import bnc_pkg::*;

    localparam int GRID_MAX = 32;
    localparam int NONE     = -1;
    localparam int OLDER    = 0;
    localparam int PRIOR    = 1;
    localparam int CURRENT  = 2;

    typedef struct {
        logic [CNT_W-1:0] count;
        logic [POS_W-1:0] row;
        logic [POS_W-1:0] col;
        logic             run_end;
        logic             frame_end;
    } box_count_t;

    class box_count_tracker;
        bit                lines [3][GRID_MAX];
        logic [POS_W-1:0]  row_pos;
        logic [POS_W-1:0]  col_pos;
        logic [SIZE_W-1:0] cols_reg;
        logic [SIZE_W-1:0] rows_reg;
        box_count_t        counts_due [$];
        int                failures;

        function new();
            clear_lines();
            row_pos  = '0;
            col_pos  = '0;
            cols_reg = RESET_SIZE;
            rows_reg = RESET_SIZE;
            failures = 0;
        endfunction

        function void clear_lines();
            foreach (lines[i, j])
                lines[i][j] = 1'b0;
        endfunction

        // zero acts as one, anything past the buffer depth saturates
        function int eff_size(logic [SIZE_W-1:0] raw);
            if (raw == 0)
                return 1;
            if (raw > GRID_MAX)
                return GRID_MAX;
            return int'(raw);
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [SIZE_W-1:0] val);
            if (idx == REG_GRID_COLS)
                cols_reg = val;
            else if (idx == REG_GRID_ROWS)
                rows_reg = val;
        endfunction

        // cells left of the grid, past the current width or in a missing row are zero
        function int tap(int line, int j, int cols);
            if (line == NONE || j < 0 || j >= cols)
                return 0;
            return lines[line][j];
        endfunction

        function int box(int top, int mid, int bot, int c, int cols);
            int s;
            s = 0;
            for (int d = -1; d <= 1; d++)
                s += tap(top, c + d, cols) + tap(mid, c + d, cols) + tap(bot, c + d, cols);
            return s;
        endfunction

        function box_count_t make_count(int cnt, int r, int c);
            box_count_t e;
            e.count     = CNT_W'(cnt);
            e.row       = POS_W'(r);
            e.col       = POS_W'(c);
            e.run_end   = 1'b0;
            e.frame_end = 1'b0;
            return e;
        endfunction

        function void take_cell(bit marked);
            box_count_t batch [$];
            int         cols;
            int         rows;
            int         r;
            int         c;
            bit         last_col;
            bit         grid_end;
            cols     = eff_size(cols_reg);
            rows     = eff_size(rows_reg);
            r        = int'(row_pos);
            c        = int'(col_pos);
            last_col = (c + 1 >= cols);
            grid_end = last_col && (r + 1 >= rows);
            lines[CURRENT][c] = marked;
            // row above is complete up to the column left of the new cell
            if (r >= 1) begin
                if (c >= 1)
                    batch.push_back(make_count(box((r >= 2) ? OLDER : NONE, PRIOR, CURRENT,
                                                   c - 1, cols), r - 1, c - 1));
                if (last_col)
                    batch.push_back(make_count(box((r >= 2) ? OLDER : NONE, PRIOR, CURRENT,
                                                   c, cols), r - 1, c));
            end
            if (grid_end) begin
                for (int j = 0; j < cols; j++)
                    batch.push_back(make_count(box((r >= 1) ? PRIOR : NONE, CURRENT, NONE,
                                                   j, cols), r, j));
                batch[batch.size() - 1].frame_end = 1'b1;
                clear_lines();
                row_pos = '0;
                col_pos = '0;
            end else if (last_col) begin
                for (int j = 0; j < GRID_MAX; j++) begin
                    lines[OLDER][j]   = lines[PRIOR][j];
                    lines[PRIOR][j]   = lines[CURRENT][j];
                    lines[CURRENT][j] = 1'b0;
                end
                row_pos = row_pos + 1'b1;
                col_pos = '0;
            end else begin
                col_pos = col_pos + 1'b1;
            end
            if (batch.size() > 0) begin
                batch[batch.size() - 1].run_end = 1'b1;
                foreach (batch[i])
                    counts_due.push_back(batch[i]);
            end
        endfunction

        function void note_failure(string what, box_count_t want, box_count_t got);
            if (failures < 10)
                $display({"%0t: %s: expected cnt=%0d row=%0d col=%0d last=%0b done=%0b,",
                          " got cnt=%0d row=%0d col=%0d last=%0b done=%0b"},
                         $time, what, want.count, want.row, want.col, want.run_end,
                         want.frame_end, got.count, got.row, got.col, got.run_end,
                         got.frame_end);
            failures++;
        endfunction

        function void match_count(logic [15:0] data, logic tlast, logic tuser);
            box_count_t want;
            box_count_t got;
            got.count     = data[CNT_W-1:0];
            got.row       = data[CNT_W +: POS_W];
            got.col       = data[CNT_W+POS_W +: POS_W];
            got.run_end   = tlast;
            got.frame_end = tuser;
            if (counts_due.size() == 0) begin
                note_failure("unexpected result", got, got);
                return;
            end
            want = counts_due.pop_front();
            if (got.count !== want.count || got.row !== want.row || got.col !== want.col ||
                got.run_end !== want.run_end || got.frame_end !== want.frame_end)
                note_failure("result mismatch", want, got);
        endfunction

        function int pending();
            return counts_due.size();
        endfunction

        function void close();
            box_count_t want;
            while (counts_due.size() > 0) begin
                want = counts_due.pop_front();
                note_failure("missing result", want, want);
            end
        endfunction
    endclass

endpackage

@@ dv/tb_top.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Streams binary grids of many sizes through the 3x3 neighbourhood counter
// and checks every count, position and marker against a tracked prediction,
// under varying sender gaps, receiver stalls and one long output hold-off.
// ----------------------------------------------------------------------------
module tb_top;

    import bnc_pkg::*;
    import box_count_check_pkg::*;

    localparam int STALL_LIMIT   = 4000;
    localparam int SETTLE_CYCLES = 40;
    localparam int HOLD_CYCLES   = 300;
    localparam int RANDOM_CELLS  = 330;

    logic                 clk;
    logic                 rst_n;
    logic                 s_axis_tvalid;
    logic                 s_axis_tready;
    logic [7:0]           s_axis_tdata;   // [0] cell_set
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [15:0]          m_axis_tdata;   // [3:0] count, [8:4] row, [13:9] col
    logic                 m_axis_tlast;   // last_of_run
    logic                 m_axis_tuser;   // frame_done
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [SIZE_W-1:0]    cfg_data;

    int                   send_idle_pct  = 0;
    int                   recv_stall_pct = 0;
    bit                   hold_req       = 1'b0;
    bit                   hold_done      = 1'b0;
    int                   held           = 0;
    int                   quiet_cycles   = 0;
    box_count_tracker     counts;

    binary_neighbourhood_count_3x3 i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // receiver: one long hold-off on request, otherwise random stalls
    always @(negedge clk)
    begin
        if (hold_req && !hold_done) begin
            m_axis_tready <= 1'b0;
            held = held + 1;
            if (held >= HOLD_CYCLES)
                hold_done = 1'b1;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
            counts.match_count(m_axis_tdata, m_axis_tlast, m_axis_tuser);
    end

    always @(posedge clk)
    begin
        if (!rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
            (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // called at a falling edge, returns at a falling edge with tvalid still high
    task automatic send_cell(bit marked);
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {7'd0, marked};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        counts.take_cell(marked);
        @(negedge clk);
    endtask

    task automatic send_pattern(logic [31:0] bits, int n);
        for (int i = 0; i < n; i++)
            send_cell(bits[i]);
        s_axis_tvalid <= 1'b0;
    endtask

    task automatic send_random(int n, int density);
        for (int i = 0; i < n; i++)
            send_cell($urandom_range(99) < density);
        s_axis_tvalid <= 1'b0;
    endtask

    task automatic write_sizes(logic [SIZE_W-1:0] cols, logic [SIZE_W-1:0] rows);
        cfg_valid <= 1'b1;
        cfg_index <= REG_GRID_COLS;
        cfg_data  <= cols;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        counts.set_reg(REG_GRID_COLS, cols);
        @(negedge clk);
        cfg_index <= REG_GRID_ROWS;
        cfg_data  <= rows;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        counts.set_reg(REG_GRID_ROWS, rows);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // drain all expected counts, then give the block time to go idle
    task automatic settle();
        @(posedge clk);
        while (counts.pending() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    initial
    begin
        int cols;
        int rows;
        int frames;
        int n;
        int sent;
        counts        = new();
        sent          = 0;
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        cfg_valid     = 1'b0;
        cfg_index     = REG_GRID_COLS;
        cfg_data      = '0;
        repeat (3) @(negedge clk);
        rst_n = 1'b1;

        // single-cell grids, where every cell ends a frame, then a 2x2 grid
        write_sizes(6'd1, 6'd1);
        send_pattern(32'b10, 2);
        settle();
        write_sizes(6'd0, 6'd0);
        send_pattern(32'b1, 1);
        settle();
        write_sizes(6'd2, 6'd2);
        send_pattern(32'hF, 4);
        settle();
        // full 3x3 gives the maximum count at the centre
        write_sizes(6'd3, 6'd3);
        send_pattern(32'h1FF, 9);
        settle();
        // narrow the grid mid-frame while sitting past the new last column
        write_sizes(6'd4, 6'd3);
        send_pattern(32'b110110, 6);
        settle();
        write_sizes(6'd2, 6'd3);
        send_pattern(32'b111, 3);
        settle();

        for (int phase = 0; sent < RANDOM_CELLS; phase++) begin
            send_idle_pct  = (phase % 4 == 1) ? 82 : (phase % 4 == 3) ? 11 : 0;
            recv_stall_pct = (phase % 4 == 2) ? 82 : (phase % 4 == 3) ? 11 : 0;
            frames = $urandom_range(1, 3);
            case (phase % 7)
                3: begin
                    cols   = (phase == 3) ? 63 : $urandom_range(32, 63);
                    rows   = $urandom_range(0, 2);
                    frames = 1;
                end
                5: begin
                    cols   = $urandom_range(0, 2);
                    rows   = (phase == 5) ? 32 : $urandom_range(32, 63);
                    frames = 1;
                end
                default: begin
                    cols = $urandom_range(1, 8);
                    rows = $urandom_range(1, 6);
                end
            endcase
            write_sizes(SIZE_W'(cols), SIZE_W'(rows));
            n = counts.eff_size(SIZE_W'(cols)) * counts.eff_size(SIZE_W'(rows)) * frames;
            // now and then stop partway so the next sizes land mid-frame
            if (phase % 6 == 4)
                n = $urandom_range(1, n);
            if (phase == 2)
                hold_req = 1'b1;
            send_random(n, $urandom_range(0, 100));
            sent += n;
            settle();
        end

        counts.close();
        if (counts.failures == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

@@ sim.f @@
hdl/bnc_pkg.sv
hdl/bnc_ctrl.sv
hdl/bnc_datapath.sv
hdl/binary_neighbourhood_count_3x3.sv
dv/box_count_check_pkg.sv
dv/tb_top.sv
